/* sv/mtt_pkg.sv */
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared sizes, operation codes and result kinds of the timer table.
// ----------------------------------------------------------------------------
package mtt_pkg;

  // Number of timer entries in the table
  localparam int TIMER_COUNT = 32;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int TIDX_W  = 5;
  localparam int QUEUE_W = 4;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 32;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 5;

  // Packed stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Operation codes carried in in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_BIND  = 3'd2,
    OP_SET   = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  // Result kinds carried in out_tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_EXP   = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_ACK   = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic CFG_TASK_INDEX  = 1'b0;
  localparam logic CFG_TASK_ENABLE = 1'b1;

endpackage

/* sv/multi_timer_table.sv */
// ----------------------------------------------------------------------------
// multi_timer_table
// Pool of countdown timers: allocate, free, bind, set-and-start and tick.
// ----------------------------------------------------------------------------
//
//  channel | direction | transaction contents
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | one operation (tuser = op, tdata = operands)
//  out_    | master    | one result (tuser = kind, tlast = final of operation)
//  cfg_    | slave     | one register write (index, data), always ready
//
//  Allocate, free, bind, set and unknown ops are answered from idle, with no walk.
//  A tick walks the count memory one entry per cycle, entry 0 first.
//  An expiry that finds the output register still held stalls the walk.
//  Reset (rst_n low, synchronous): all entries free, tick counter and
//  registers zero; no clearing pass is needed.
//
module multi_timer_table (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: timer_index[4:0], dest_queue[8:5], event_byte[16:9],
  //           timeout_ticks[48:17], zero fill above
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mtt_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: op[2:0]
  input  logic [mtt_pkg::OP_W-1:0]        in_tuser,
  // out_tdata: ok[0], result_index[5:1], out_queue[9:6], out_byte[17:10],
  //            task_switch[18], tick_total[50:19], zero fill above
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mtt_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: kind[1:0]
  output logic [mtt_pkg::KIND_W-1:0]      out_tuser,
  output logic                            out_tlast,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [mtt_pkg::CFG_W-1:0]       cfg_data
);

  localparam int IDX_W = mtt_pkg::IDX_W;
  localparam int CMP_W = (IDX_W > mtt_pkg::TIDX_W) ? IDX_W : mtt_pkg::TIDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(mtt_pkg::TIMER_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // Control state
  state_t                          state_r;
  logic                            out_valid_r;
  logic [mtt_pkg::TIMER_COUNT-1:0] free_r;
  logic [mtt_pkg::TIMER_COUNT-1:0] run_r;
  logic [mtt_pkg::CNT_W-1:0]       tick_r;
  logic [mtt_pkg::TIDX_W-1:0]      task_idx_r;
  logic                            task_en_r;
  logic [IDX_W-1:0]                ev_r;
  logic                            sw_r;

  // Output payload
  logic [mtt_pkg::KIND_W-1:0]      out_kind_r;
  logic                            out_ok_r;
  logic [mtt_pkg::TIDX_W-1:0]      out_idx_r;
  logic [mtt_pkg::QUEUE_W-1:0]     out_queue_r;
  logic [mtt_pkg::BYTE_W-1:0]      out_byte_r;
  logic                            out_sw_r;
  logic [mtt_pkg::CNT_W-1:0]       out_total_r;
  logic                            out_last_r;

  // Next output payload
  logic                            out_load;
  logic                            out_valid_nxt;
  logic [mtt_pkg::KIND_W-1:0]      out_kind_nxt;
  logic                            out_ok_nxt;
  logic [mtt_pkg::TIDX_W-1:0]      out_idx_nxt;
  logic [mtt_pkg::QUEUE_W-1:0]     out_queue_nxt;
  logic [mtt_pkg::BYTE_W-1:0]      out_byte_nxt;
  logic                            out_sw_nxt;
  logic [mtt_pkg::CNT_W-1:0]       out_total_nxt;
  logic                            out_last_nxt;

  // Memories: count, and queue/byte
  logic [mtt_pkg::CNT_W-1:0]                     cnt_mem [mtt_pkg::TIMER_COUNT];
  logic [mtt_pkg::QUEUE_W+mtt_pkg::BYTE_W-1:0]   qb_mem  [mtt_pkg::TIMER_COUNT];
  logic [mtt_pkg::CNT_W-1:0]                     cnt_rd_r;
  logic [mtt_pkg::QUEUE_W+mtt_pkg::BYTE_W-1:0]   qb_rd_r;

  // Input fields
  logic [mtt_pkg::TIDX_W-1:0]  in_idx;
  logic [mtt_pkg::QUEUE_W-1:0] in_queue;
  logic [mtt_pkg::BYTE_W-1:0]  in_byte;
  logic [mtt_pkg::CNT_W-1:0]   in_tmo;
  logic [IDX_W-1:0]            in_addr;
  logic                        in_valid_idx;
  logic                        in_fire;
  logic                        slot_free;

  // Walk and memory port control
  logic                        hit;
  logic                        expire;
  logic                        walk_go;
  logic [mtt_pkg::CNT_W-1:0]   cnt_dec;
  logic [IDX_W-1:0]            rd_addr;
  logic                        cnt_we;
  logic [IDX_W-1:0]            cnt_wa;
  logic [mtt_pkg::CNT_W-1:0]   cnt_wd;
  logic                        qb_we;

  // Allocate search
  logic                        alloc_hit;
  logic [IDX_W-1:0]            alloc_idx;

  // Field unpacking
  assign in_idx       = in_tdata[4:0];
  assign in_queue     = in_tdata[8:5];
  assign in_byte      = in_tdata[16:9];
  assign in_tmo       = in_tdata[48:17];
  assign in_addr      = IDX_W'(in_idx);
  assign in_valid_idx = (32'(in_idx) < 32'(mtt_pkg::TIMER_COUNT));

  // Handshakes
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Walk step on the entry whose data is in the read register
  assign cnt_dec = cnt_rd_r - 1'b1;
  assign hit     = (state_r == S_WALK) && run_r[ev_r] && (cnt_rd_r != '0);
  assign expire  = hit && (cnt_dec == '0);
  assign walk_go = !expire || slot_free;

  // Lowest free entry
  always_comb begin
    alloc_hit = 1'b0;
    alloc_idx = '0;
    for (int i = mtt_pkg::TIMER_COUNT - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        alloc_hit = 1'b1;
        alloc_idx = IDX_W'(i);
      end
    end
  end

  // Result register load and next payload
  always_comb begin
    out_load      = 1'b0;
    out_kind_nxt  = mtt_pkg::KIND_ACK;
    out_ok_nxt    = 1'b1;
    out_idx_nxt   = '0;
    out_queue_nxt = '0;
    out_byte_nxt  = '0;
    out_sw_nxt    = 1'b0;
    out_total_nxt = '0;
    out_last_nxt  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        // a tick answers only after its walk
        out_load = in_fire && (in_tuser != mtt_pkg::OP_TICK);
        if (in_tuser == mtt_pkg::OP_ALLOC) begin
          out_kind_nxt = mtt_pkg::KIND_ALLOC;
          out_ok_nxt   = alloc_hit;
          out_idx_nxt  = mtt_pkg::TIDX_W'(alloc_idx);
        end
      end
      S_WALK: begin
        out_load      = expire && walk_go;
        out_kind_nxt  = mtt_pkg::KIND_EXP;
        out_idx_nxt   = mtt_pkg::TIDX_W'(ev_r);
        out_queue_nxt = qb_rd_r[mtt_pkg::QUEUE_W+mtt_pkg::BYTE_W-1:mtt_pkg::BYTE_W];
        out_byte_nxt  = qb_rd_r[mtt_pkg::BYTE_W-1:0];
        out_total_nxt = tick_r;
        out_last_nxt  = 1'b0;
      end
      S_DONE: begin
        out_load      = slot_free;
        out_kind_nxt  = mtt_pkg::KIND_TICK;
        out_sw_nxt    = sw_r;
        out_total_nxt = tick_r;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  // Memory address and write selection
  always_comb begin
    rd_addr = '0;
    cnt_we  = 1'b0;
    cnt_wa  = in_addr;
    cnt_wd  = in_tmo;
    qb_we   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cnt_we = in_fire && in_valid_idx && (in_tuser == mtt_pkg::OP_SET);
        qb_we  = in_fire && in_valid_idx && (in_tuser == mtt_pkg::OP_BIND);
      end
      S_WALK: begin
        rd_addr = walk_go ? ev_r + 1'b1 : ev_r;
        cnt_we  = hit && walk_go;
        cnt_wa  = ev_r;
        cnt_wd  = cnt_dec;
      end
      S_DONE: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[rd_addr];
  end

  // Queue/byte memory
  always_ff @(posedge clk) begin
    if (qb_we) begin
      qb_mem[in_addr] <= {in_queue, in_byte};
    end
    qb_rd_r <= qb_mem[rd_addr];
  end

  // Sequencer, entry flags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_r      <= '1;
      run_r       <= '0;
      tick_r      <= '0;
      task_idx_r  <= '0;
      task_en_r   <= 1'b0;
      ev_r        <= '0;
      sw_r        <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mtt_pkg::CFG_TASK_INDEX:  task_idx_r <= cfg_data;
          mtt_pkg::CFG_TASK_ENABLE: task_en_r  <= cfg_data[0];
          default: ;
        endcase
      end

      // result register
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        out_kind_r  <= out_kind_nxt;
        out_ok_r    <= out_ok_nxt;
        out_idx_r   <= out_idx_nxt;
        out_queue_r <= out_queue_nxt;
        out_byte_r  <= out_byte_nxt;
        out_sw_r    <= out_sw_nxt;
        out_total_r <= out_total_nxt;
        out_last_r  <= out_last_nxt;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_tuser)
              mtt_pkg::OP_ALLOC: begin
                if (alloc_hit) begin
                  free_r[alloc_idx] <= 1'b0;
                end
              end
              mtt_pkg::OP_FREE: begin
                if (in_valid_idx) begin
                  free_r[in_addr] <= 1'b1;
                  run_r[in_addr]  <= 1'b0;
                end
              end
              mtt_pkg::OP_SET: begin
                if (in_valid_idx) begin
                  free_r[in_addr] <= 1'b0;
                  run_r[in_addr]  <= 1'b1;
                end
              end
              mtt_pkg::OP_TICK: begin
                // walk starts with entry 0 in the read register
                tick_r  <= tick_r + 1'b1;
                sw_r    <= 1'b0;
                ev_r    <= '0;
                state_r <= S_WALK;
              end
              default: ;
            endcase
          end
        end

        S_WALK: begin
          if (walk_go) begin
            if (expire) begin
              run_r[ev_r] <= 1'b0;
              if (task_en_r && (CMP_W'(ev_r) == CMP_W'(task_idx_r))) begin
                sw_r <= 1'b1;
              end
            end
            if (ev_r == LAST_IDX) begin
              state_r <= S_DONE;
            end else begin
              ev_r <= ev_r + 1'b1;
            end
          end
        end

        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_total_r, out_sw_r, out_byte_r, out_queue_r,
                       out_idx_r, out_ok_r};

endmodule

/* sv/mtt_checker.sv */
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks of the timer table's result stream.
// ----------------------------------------------------------------------------
module mtt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mtt_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [mtt_pkg::KIND_W-1:0]      out_tuser,
  input logic                            out_tlast
);

  // Held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result payload changed while stalled");

  // Tick done always closes the operation
  a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mtt_pkg::KIND_TICK) |-> out_tlast)
    else $error("tick done without tlast");

  // Expiries are never the final result
  a_exp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mtt_pkg::KIND_EXP) |-> !out_tlast)
    else $error("expiry marked last");

  // No new operation while a tick is still emitting
  a_busy_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted during tick walk");

  // Only an allocate answer may report failure
  a_ok_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tuser == mtt_pkg::KIND_ALLOC))
    else $error("ok low on a non-allocate result");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
